[hw/rtl/eicl_pkg.sv]
`timescale 1ns / 1ps

// Shared types and constants of the edge interval capture log.
package eicl_pkg;

    // Timebase, sequence and log geometry.
    localparam int TIME_WIDTH  = 32;
    localparam int SEQ_WIDTH   = 32;
    localparam int LOG_DEPTH   = 32;
    localparam int PTR_WIDTH   = $clog2(LOG_DEPTH);
    localparam int CHAN_COUNT  = 2;
    localparam int CHAN_WIDTH  = 1;

    // Result queue geometry.
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 3);

    // Item operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // One record of a channel log.
    typedef struct packed {
        logic [SEQ_WIDTH-1:0]  sequence_num;
        logic [TIME_WIDTH-1:0] interval;
        logic                  level;
    } entry_t;

    // Per-channel control for the stage that owns the log state.
    typedef struct packed {
        logic                 tick;
        logic                 level;
        logic                 rd_en;
        logic [PTR_WIDTH-1:0] rd_position;
    } chan_ctl_t;

endpackage

[hw/rtl/eicl_cmd_if.sv]
`timescale 1ns / 1ps

// Input channel: one item is a tick with pin levels or a log read.
interface eicl_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic                          level_ch0;
    logic                          level_ch1;
    logic [eicl_pkg::CHAN_WIDTH-1:0] read_channel;
    logic [eicl_pkg::PTR_WIDTH-1:0]  read_position;

    modport source (
        output valid, opcode, level_ch0, level_ch1, read_channel, read_position,
        input  ready
    );

    modport sink (
        input  valid, opcode, level_ch0, level_ch1, read_channel, read_position,
        output ready
    );
endinterface

[hw/rtl/eicl_rsp_if.sv]
`timescale 1ns / 1ps

// Output channel: one item is one log entry.
interface eicl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [eicl_pkg::SEQ_WIDTH-1:0]  entry_sequence;
    logic [eicl_pkg::TIME_WIDTH-1:0] entry_interval;
    logic                            entry_level;

    modport source (
        output valid, entry_sequence, entry_interval, entry_level,
        input  ready
    );

    modport sink (
        input  valid, entry_sequence, entry_interval, entry_level,
        output ready
    );
endinterface

[hw/rtl/edge_interval_capture_log.sv]
`timescale 1ns / 1ps

// Channel  Role    Handshake      Payload
// cmd      sink    valid/ready    opcode, level_ch0, level_ch1, read_channel, read_position
// rsp      source  valid/ready    entry_sequence, entry_interval, entry_level
//
// One item is accepted per cycle while cmd.ready is high. A tick updates the timebase and the logs
// in the cycle after it is accepted; a read passes the input register, the log read register and
// the result queue before its result is offered on rsp. Reset clears the timebase, the channel
// state and the written flags of every slot, so no clearing pass is needed. cmd.ready drops only
// when the four-entry result queue, counting reads still in flight, would be full.
module edge_interval_capture_log (
    input  logic        clk,
    input  logic        rst_n,
    eicl_cmd_if.sink    cmd,
    eicl_rsp_if.source  rsp
);

    logic                                   s1_valid_reg;
    logic                                   s1_opcode_reg;
    logic                                   s1_level0_reg;
    logic                                   s1_level1_reg;
    logic [eicl_pkg::CHAN_WIDTH-1:0]        s1_channel_reg;
    logic [eicl_pkg::PTR_WIDTH-1:0]         s1_position_reg;
    logic                                   s2_valid_reg;
    logic [eicl_pkg::CHAN_WIDTH-1:0]        s2_channel_reg;
    logic [eicl_pkg::TIME_WIDTH-1:0]        tick_count_reg;

    logic                                   accept;
    logic                                   s1_tick;
    logic                                   s1_read;
    logic [eicl_pkg::TIME_WIDTH-1:0]        tick_next;
    logic [eicl_pkg::RES_CNT_W-1:0]         queue_count;
    logic [eicl_pkg::RES_CNT_W-1:0]         pending;
    logic [eicl_pkg::CHAN_COUNT-1:0]        chan_level;
    eicl_pkg::chan_ctl_t                    chan_ctl   [eicl_pkg::CHAN_COUNT];
    eicl_pkg::entry_t                       chan_entry [eicl_pkg::CHAN_COUNT];

    // Admission: reserve a queue slot for every read still in flight.
    assign pending = queue_count
                   + {{(eicl_pkg::RES_CNT_W-1){1'b0}}, s1_valid_reg && s1_opcode_reg}
                   + {{(eicl_pkg::RES_CNT_W-1){1'b0}}, s2_valid_reg};
    assign cmd.ready = (pending < eicl_pkg::RES_CNT_W'(eicl_pkg::RES_DEPTH));
    assign accept    = cmd.valid && cmd.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg   <= cmd.opcode;
            s1_level0_reg   <= cmd.level_ch0;
            s1_level1_reg   <= cmd.level_ch1;
            s1_channel_reg  <= cmd.read_channel;
            s1_position_reg <= cmd.read_position;
        end
    end

    assign s1_tick   = s1_valid_reg && (s1_opcode_reg == eicl_pkg::OP_TICK);
    assign s1_read   = s1_valid_reg && (s1_opcode_reg == eicl_pkg::OP_READ);
    assign tick_next = tick_count_reg + 1'b1;

    // Timebase: the incremented count stamps any edge seen on this tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else if (s1_tick)
        begin
            tick_count_reg <= tick_next;
        end
    end

    assign chan_level = {s1_level1_reg, s1_level0_reg};

    // One log per channel.
    for (genvar ch = 0; ch < eicl_pkg::CHAN_COUNT; ch++)
    begin : g_chan
        always_comb
        begin
            chan_ctl[ch].tick        = s1_tick;
            chan_ctl[ch].level       = chan_level[ch];
            chan_ctl[ch].rd_en       =
                s1_read && (s1_channel_reg == eicl_pkg::CHAN_WIDTH'(ch));
            chan_ctl[ch].rd_position = s1_position_reg;
        end

        eicl_channel_log u_log (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (chan_ctl[ch]),
            .stamp    (tick_next),
            .rd_entry (chan_entry[ch])
        );
    end

    // Read result stage: the log read data is valid here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_read)
        begin
            s2_channel_reg <= s1_channel_reg;
        end
    end

    eicl_result_fifo u_results (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (chan_entry[s2_channel_reg]),
        .rsp       (rsp),
        .count     (queue_count)
    );

    // The queue never holds more than its depth together with reads in flight.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= eicl_pkg::RES_CNT_W'(eicl_pkg::RES_DEPTH))
        else $error("result queue over-committed");

    // An accepted read passes the input register and then reaches the result stage.
    a_read_reaches_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == eicl_pkg::OP_READ) |-> ##2 s2_valid_reg)
        else $error("read item lost before the result stage");

    // The timebase moves only on a tick item.
    a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_tick |=> $stable(tick_count_reg))
        else $error("timebase changed without a tick");

endmodule

[hw/rtl/eicl_channel_log.sv]
`timescale 1ns / 1ps

// Edge detector, interval timer and record ring of one channel.
module eicl_channel_log (
    input  logic                                clk,
    input  logic                                rst_n,
    input  eicl_pkg::chan_ctl_t                 ctl,
    input  logic [eicl_pkg::TIME_WIDTH-1:0]     stamp,
    output eicl_pkg::entry_t                    rd_entry
);

    logic                               prev_level_reg;
    logic [eicl_pkg::TIME_WIDTH-1:0]    last_edge_reg;
    logic [eicl_pkg::SEQ_WIDTH-1:0]     seq_reg;
    logic [eicl_pkg::PTR_WIDTH-1:0]     wp_reg;
    logic [eicl_pkg::LOG_DEPTH-1:0]     written_reg;
    eicl_pkg::entry_t                   log_mem [eicl_pkg::LOG_DEPTH];
    eicl_pkg::entry_t                   rd_data_reg;
    logic                               rd_hit_reg;

    logic                               edge_seen;
    logic [eicl_pkg::SEQ_WIDTH-1:0]     seq_next;
    logic [eicl_pkg::PTR_WIDTH-1:0]     rd_addr;
    eicl_pkg::entry_t                   wr_entry;

    // A tick whose level differs from the last sample is an edge.
    assign edge_seen = ctl.tick && (ctl.level != prev_level_reg);
    assign seq_next  = seq_reg + 1'b1;
    assign rd_addr   = wp_reg + ctl.rd_position;

    always_comb
    begin
        wr_entry.sequence_num = seq_next;
        wr_entry.interval     = stamp - last_edge_reg;
        wr_entry.level        = ctl.level;
    end

    // Channel state and the written flag of each ring slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            last_edge_reg  <= '0;
            seq_reg        <= '0;
            wp_reg         <= '0;
            written_reg    <= '0;
        end
        else if (edge_seen)
        begin
            prev_level_reg      <= ctl.level;
            last_edge_reg       <= stamp;
            seq_reg             <= seq_next;
            wp_reg              <= wp_reg + 1'b1;
            written_reg[wp_reg] <= 1'b1;
        end
    end

    // Ring storage, written on an edge.
    always_ff @(posedge clk)
    begin
        if (edge_seen)
        begin
            log_mem[wp_reg] <= wr_entry;
        end
    end

    // Registered read; a slot never written reads as zero.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= log_mem[rd_addr];
            rd_hit_reg  <= written_reg[rd_addr];
        end
    end

    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule

[hw/rtl/eicl_result_fifo.sv]
`timescale 1ns / 1ps

// Small queue that holds finished results until the sink takes them.
module eicl_result_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  eicl_pkg::entry_t                  push_data,
    eicl_rsp_if.source                        rsp,
    output logic [eicl_pkg::RES_CNT_W-1:0]    count
);

    eicl_pkg::entry_t                   slot_reg [eicl_pkg::RES_DEPTH];
    logic [eicl_pkg::RES_PTR_W-1:0]     wr_ptr_reg;
    logic [eicl_pkg::RES_PTR_W-1:0]     rd_ptr_reg;
    logic [eicl_pkg::RES_CNT_W-1:0]     count_reg;
    logic                               pop;

    assign pop   = rsp.valid && rsp.ready;
    assign count = count_reg;

    // Head of the queue drives the output channel.
    assign rsp.valid          = (count_reg != '0);
    assign rsp.entry_sequence = slot_reg[rd_ptr_reg].sequence_num;
    assign rsp.entry_interval = slot_reg[rd_ptr_reg].interval;
    assign rsp.entry_level    = slot_reg[rd_ptr_reg].level;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
